// File: src/hbs_pkg.sv
// Package for the hit bucket segmenter: field widths, register indexes,
// reset values, the stored entry layout and the controller state type.
// No dependencies; every other file of the block but hbs_ram uses it.
package hbs_pkg;

  // Store depth default.
  localparam int BUCKET_DEPTH = 32;

  // Field widths.
  localparam int Z_W     = 20;
  localparam int SIGMA_W = 16;
  localparam int TAG_W   = 16;
  localparam int UPPER_W = 22;
  localparam int BNUM_W  = 16;
  localparam int WIN_W   = 20;
  localparam int SCALE_W = 8;
  localparam int MIN_W   = 6;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_WINDOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_SCALE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BUCKET_SIZE = 3'd4;

  localparam logic [WIN_W-1:0]   RST_MAX_WINDOW      = 20'd16000;
  localparam logic [WIN_W-1:0]   RST_NEIGHBOR_WINDOW = 20'd4000;
  localparam logic [WIN_W-1:0]   RST_OVERLAP_WINDOW  = 20'd1600;
  localparam logic [SCALE_W-1:0] RST_SIGMA_SCALE     = 8'd16;
  localparam logic [MIN_W-1:0]   RST_MIN_BUCKET_SIZE = 6'd1;

  // Configuration registers as seen by the controller.
  typedef struct packed {
    logic [WIN_W-1:0]   max_window;
    logic [WIN_W-1:0]   neighbor_window;
    logic [WIN_W-1:0]   overlap_window;
    logic [SCALE_W-1:0] sigma_scale;
    logic [MIN_W-1:0]   min_bucket_size;
  } cfg_t;

  // One stored hit.
  typedef struct packed {
    logic [Z_W-1:0]     z;
    logic [UPPER_W-1:0] upper;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT_RD,
    S_EMIT_WAIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_PUSH,
    S_FLUSH
  } hbs_state_t;

endpackage

// File: src/hbs_if.sv
// Valid/ready channel interfaces for hit items in and bucket hit items out.
// Depends on hbs_pkg for field widths.
interface hbs_in_if;
  logic                            valid;
  logic                            ready;
  logic [hbs_pkg::Z_W-1:0]         point_z;
  logic [hbs_pkg::SIGMA_W-1:0]     point_sigma;
  logic [hbs_pkg::TAG_W-1:0]       point_tag;
  logic                            sector_end;

  modport source (output valid, point_z, point_sigma, point_tag, sector_end, input ready);
  modport sink   (input valid, point_z, point_sigma, point_tag, sector_end, output ready);
endinterface

interface hbs_out_if;
  logic                            valid;
  logic                            ready;
  logic [hbs_pkg::BNUM_W-1:0]      bucket_number;
  logic [hbs_pkg::TAG_W-1:0]       out_tag;
  logic [hbs_pkg::Z_W-1:0]         out_z;
  logic                            bucket_last;

  modport source (output valid, bucket_number, out_tag, out_z, bucket_last, input ready);
  modport sink   (input valid, bucket_number, out_tag, out_z, bucket_last, output ready);
endinterface

// File: src/hbs_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module hbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/hbs_cfg.sv
// Configuration register bank, written by index, no read-back.
// Depends on hbs_pkg for indexes, reset values and cfg_t.
module hbs_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0] cfg_data,
  output hbs_pkg::cfg_t                  cfg
);

  hbs_pkg::cfg_t cfg_r, cfg_nxt;

  // Index decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        hbs_pkg::CFG_MAX_WINDOW:      cfg_nxt.max_window      = cfg_data;
        hbs_pkg::CFG_NEIGHBOR_WINDOW: cfg_nxt.neighbor_window = cfg_data;
        hbs_pkg::CFG_OVERLAP_WINDOW:  cfg_nxt.overlap_window  = cfg_data;
        hbs_pkg::CFG_SIGMA_SCALE:     cfg_nxt.sigma_scale     = cfg_data[hbs_pkg::SCALE_W-1:0];
        hbs_pkg::CFG_MIN_BUCKET_SIZE: cfg_nxt.min_bucket_size = cfg_data[hbs_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_window      <= hbs_pkg::RST_MAX_WINDOW;
      cfg_r.neighbor_window <= hbs_pkg::RST_NEIGHBOR_WINDOW;
      cfg_r.overlap_window  <= hbs_pkg::RST_OVERLAP_WINDOW;
      cfg_r.sigma_scale     <= hbs_pkg::RST_SIGMA_SCALE;
      cfg_r.min_bucket_size <= hbs_pkg::RST_MIN_BUCKET_SIZE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/hbs_ctrl.sv
// Bucket controller: split decision, emission, overlap scan and append over a
// ring-addressed entry RAM. Depends on hbs_pkg and hbs_if; drives hbs_ram.
module hbs_ctrl #(
  parameter int BUCKET_DEPTH = hbs_pkg::BUCKET_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hbs_pkg::cfg_t                    cfg,
  hbs_in_if.sink                           in_ch,
  hbs_out_if.source                        out_ch,
  output logic                             mem_we,
  output logic [$clog2(BUCKET_DEPTH)-1:0]  mem_waddr,
  output hbs_pkg::entry_t                  mem_wdata,
  output logic                             mem_re,
  output logic [$clog2(BUCKET_DEPTH)-1:0]  mem_raddr,
  input  hbs_pkg::entry_t                  mem_rdata
);

  localparam int AW = $clog2(BUCKET_DEPTH);
  localparam int CW = $clog2(BUCKET_DEPTH + 1);
  localparam int ZW = hbs_pkg::Z_W;
  localparam int UW = hbs_pkg::UPPER_W;

  // Logical index i of the bucket lives at (base + i) mod depth.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(i);
    if (s >= (CW+1)'(BUCKET_DEPTH)) begin
      s = s - (CW+1)'(BUCKET_DEPTH);
    end
    return AW'(s);
  endfunction

  hbs_pkg::hbs_state_t state_r, state_nxt;

  logic [CW-1:0]               count_r, count_nxt;
  logic [AW-1:0]               base_r, base_nxt;
  logic [ZW-1:0]               first_z_r, first_z_nxt;
  logic [ZW-1:0]               last_z_r, last_z_nxt;
  logic [hbs_pkg::BNUM_W-1:0]  emitted_r, emitted_nxt;
  logic [hbs_pkg::BNUM_W-1:0]  bnum_r, bnum_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        flush_r, flush_nxt;

  // Held item
  logic [ZW-1:0]               z_r, z_nxt;
  logic [UW-1:0]               upper_r, upper_nxt;
  logic [hbs_pkg::TAG_W-1:0]   tag_r, tag_nxt;
  logic                        end_r, end_nxt;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  logic [hbs_pkg::BNUM_W-1:0]  out_bnum_r, out_bnum_nxt;
  logic [hbs_pkg::TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic [ZW-1:0]               out_z_r, out_z_nxt;
  logic                        out_last_r, out_last_nxt;

  // Incoming item arithmetic
  logic                                          in_fire;
  logic [hbs_pkg::SIGMA_W+hbs_pkg::SCALE_W-1:0]  sig_prod;
  logic [UW-1:0]                                 upper_in;
  logic [UW-1:0]                                 d_first;
  logic [UW-1:0]                                 d_last;
  logic                                          split_in;
  logic                                          emit_ok;
  logic [UW:0]                                   d_scan;
  logic                                          scan_pass;

  assign in_fire = in_ch.valid && in_ch.ready;

  // Upper edge: z + floor(sigma * scale / 16)
  assign sig_prod = in_ch.point_sigma * cfg.sigma_scale;
  assign upper_in = {{(UW-ZW){in_ch.point_z[ZW-1]}}, in_ch.point_z}
                  + {2'b00, sig_prod[hbs_pkg::SIGMA_W+hbs_pkg::SCALE_W-1:4]};

  // Split test: store full, or too far from the first or last stored z
  assign d_first = {{(UW-ZW){in_ch.point_z[ZW-1]}}, in_ch.point_z}
                 - {{(UW-ZW){first_z_r[ZW-1]}}, first_z_r};
  assign d_last  = {{(UW-ZW){in_ch.point_z[ZW-1]}}, in_ch.point_z}
                 - {{(UW-ZW){last_z_r[ZW-1]}}, last_z_r};
  assign split_in = (count_r != '0)
                 && ((count_r == CW'(BUCKET_DEPTH))
                  || ($signed(d_first) > $signed({2'b00, cfg.max_window}))
                  || ($signed(d_last)  > $signed({2'b00, cfg.neighbor_window})));

  // Bucket large enough to emit (count is nonzero wherever this is used)
  assign emit_ok = hbs_pkg::MIN_W'(count_r) >= cfg.min_bucket_size;

  // Overlap test on the entry just read
  assign d_scan = {{(UW+1-ZW){z_r[ZW-1]}}, z_r} - {mem_rdata.upper[UW-1], mem_rdata.upper};
  assign scan_pass = $signed(d_scan) < $signed({3'b000, cfg.overlap_window});

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    base_nxt      = base_r;
    first_z_nxt   = first_z_r;
    last_z_nxt    = last_z_r;
    emitted_nxt   = emitted_r;
    bnum_nxt      = bnum_r;
    idx_nxt       = idx_r;
    flush_nxt     = flush_r;
    z_nxt         = z_r;
    upper_nxt     = upper_r;
    tag_nxt       = tag_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_bnum_nxt  = out_bnum_r;
    out_tag_nxt   = out_tag_r;
    out_z_nxt     = out_z_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = phys(base_r, count_r);
    mem_wdata     = '{z: z_r, upper: upper_r, tag: tag_r};
    mem_re        = 1'b0;
    mem_raddr     = phys(base_r, idx_r);

    unique case (state_r)
      hbs_pkg::S_IDLE: begin
        if (in_fire) begin
          z_nxt     = in_ch.point_z;
          upper_nxt = upper_in;
          tag_nxt   = in_ch.point_tag;
          end_nxt   = in_ch.sector_end;
          if (split_in) begin
            idx_nxt = '0;
            if (emit_ok) begin
              flush_nxt   = 1'b0;
              emitted_nxt = emitted_r + hbs_pkg::BNUM_W'(1);
              bnum_nxt    = emitted_r + hbs_pkg::BNUM_W'(1);
              state_nxt   = hbs_pkg::S_EMIT_RD;
            end else begin
              state_nxt = hbs_pkg::S_SCAN_RD;
            end
          end else begin
            // Plain append in the accept cycle
            mem_we     = 1'b1;
            mem_wdata  = '{z: in_ch.point_z, upper: upper_in, tag: in_ch.point_tag};
            count_nxt  = count_r + CW'(1);
            last_z_nxt = in_ch.point_z;
            if (count_r == '0) begin
              first_z_nxt = in_ch.point_z;
            end
            state_nxt = in_ch.sector_end ? hbs_pkg::S_FLUSH : hbs_pkg::S_IDLE;
          end
        end
      end

      hbs_pkg::S_EMIT_RD: begin
        // Read only once the output register is free next cycle
        if (!out_valid_r || out_ch.ready) begin
          mem_re    = 1'b1;
          mem_raddr = phys(base_r, idx_r);
          state_nxt = hbs_pkg::S_EMIT_WAIT;
        end
      end

      hbs_pkg::S_EMIT_WAIT: begin
        out_valid_nxt = 1'b1;
        out_bnum_nxt  = bnum_r;
        out_tag_nxt   = mem_rdata.tag;
        out_z_nxt     = mem_rdata.z;
        out_last_nxt  = (idx_r == count_r - CW'(1));
        idx_nxt       = idx_r + CW'(1);
        if (idx_r == count_r - CW'(1)) begin
          if (flush_r) begin
            count_nxt   = '0;
            base_nxt    = '0;
            first_z_nxt = '0;
            emitted_nxt = '0;
            state_nxt   = hbs_pkg::S_IDLE;
          end else begin
            idx_nxt   = '0;
            state_nxt = hbs_pkg::S_SCAN_RD;
          end
        end else begin
          state_nxt = hbs_pkg::S_EMIT_RD;
        end
      end

      hbs_pkg::S_SCAN_RD: begin
        // Walk back from the newest entry; idx counts kept entries
        if ((idx_r < count_r) && (idx_r < CW'(BUCKET_DEPTH - 1))) begin
          mem_re    = 1'b1;
          mem_raddr = phys(base_r, count_r - idx_r - CW'(1));
          state_nxt = hbs_pkg::S_SCAN_CHK;
        end else begin
          base_nxt  = phys(base_r, count_r - idx_r);
          count_nxt = idx_r;
          state_nxt = hbs_pkg::S_PUSH;
        end
      end

      hbs_pkg::S_SCAN_CHK: begin
        if (scan_pass) begin
          idx_nxt     = idx_r + CW'(1);
          first_z_nxt = mem_rdata.z;
          state_nxt   = hbs_pkg::S_SCAN_RD;
        end else begin
          base_nxt  = phys(base_r, count_r - idx_r);
          count_nxt = idx_r;
          state_nxt = hbs_pkg::S_PUSH;
        end
      end

      hbs_pkg::S_PUSH: begin
        mem_we     = 1'b1;
        count_nxt  = count_r + CW'(1);
        last_z_nxt = z_r;
        if (count_r == '0) begin
          first_z_nxt = z_r;
        end
        state_nxt = end_r ? hbs_pkg::S_FLUSH : hbs_pkg::S_IDLE;
      end

      hbs_pkg::S_FLUSH: begin
        if (emit_ok) begin
          idx_nxt     = '0;
          flush_nxt   = 1'b1;
          emitted_nxt = emitted_r + hbs_pkg::BNUM_W'(1);
          bnum_nxt    = emitted_r + hbs_pkg::BNUM_W'(1);
          state_nxt   = hbs_pkg::S_EMIT_RD;
        end else begin
          count_nxt   = '0;
          base_nxt    = '0;
          first_z_nxt = '0;
          emitted_nxt = '0;
          state_nxt   = hbs_pkg::S_IDLE;
        end
      end

      default: state_nxt = hbs_pkg::S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hbs_pkg::S_IDLE;
      count_r     <= '0;
      base_r      <= '0;
      first_z_r   <= '0;
      last_z_r    <= '0;
      emitted_r   <= '0;
      idx_r       <= '0;
      flush_r     <= 1'b0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      base_r      <= base_nxt;
      first_z_r   <= first_z_nxt;
      last_z_r    <= last_z_nxt;
      emitted_r   <= emitted_nxt;
      idx_r       <= idx_nxt;
      flush_r     <= flush_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    bnum_r     <= bnum_nxt;
    z_r        <= z_nxt;
    upper_r    <= upper_nxt;
    tag_r      <= tag_nxt;
    out_bnum_r <= out_bnum_nxt;
    out_tag_r  <= out_tag_nxt;
    out_z_r    <= out_z_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready          = (state_r == hbs_pkg::S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.bucket_number = out_bnum_r;
  assign out_ch.out_tag       = out_tag_r;
  assign out_ch.out_z         = out_z_r;
  assign out_ch.bucket_last   = out_last_r;

endmodule

// File: src/hit_bucket_segmenter_with_overlap_core.sv
// Top level of the hit bucket segmenter: config bank, controller, entry RAM.
// Depends on hbs_pkg, hbs_if, hbs_ram, hbs_cfg and hbs_ctrl.
//
//  Channel  Direction  Handshake        Payload
//  in_ch    in         valid/ready      point_z, point_sigma, point_tag, sector_end
//  out_ch   out        valid/ready      bucket_number, out_tag, out_z, bucket_last
//  cfg_*    in         cfg_we, no wait  cfg_index, cfg_data
//
// A hit that does not close the bucket is appended in its accept cycle.
// A closing hit emits the bucket if it is large enough, one RAM read per
// emitted hit, then reads back from the newest entry while entries overlap,
// then appends; sector end then flushes the bucket if it is large enough.
// The single RAM read port, one read per step, sets the pace of this.
// Reset is synchronous; the RAM needs no clearing since only written entries
// are read. A stalled output holds the emission; input waits while busy.
module hit_bucket_segmenter_with_overlap_core #(
  parameter int BUCKET_DEPTH = hbs_pkg::BUCKET_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hbs_in_if.sink                         in_ch,
  hbs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(BUCKET_DEPTH);

  hbs_pkg::cfg_t   cfg;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  hbs_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  hbs_pkg::entry_t mem_rdata;

  // Configuration registers
  hbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Bucket controller
  hbs_ctrl #(
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Entry store
  hbs_ram #(
    .WIDTH (hbs_pkg::ENTRY_W),
    .DEPTH (BUCKET_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: src/hbs_checker.sv
// Port-level checker for the hit bucket segmenter, bound to the top level.
// Depends on hbs_if and hit_bucket_segmenter_with_overlap_core.
module hbs_checker (
  input logic        clk,
  input logic        rst_n,
  hbs_in_if.sink     in_ch,
  hbs_out_if.source  out_ch
);

  // Stalled result holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.out_tag)
      && $stable(out_ch.out_z) && $stable(out_ch.bucket_number)
      && $stable(out_ch.bucket_last))
    else $error("result item changed while stalled");

  // A sector end always leaves work behind it
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.sector_end |=> !in_ch.ready)
    else $error("input taken right after sector end");

  // No new hit accepted while a bucket is still being emitted
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.bucket_last |=> !in_ch.ready)
    else $error("input taken in the middle of a bucket");

  // Each emitted hit needs a RAM read before the next result
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready |=> !out_ch.valid)
    else $error("result follows previous without a read cycle");

endmodule

bind hit_bucket_segmenter_with_overlap_core hbs_checker u_hbs_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

// File: tb/tb_top.sv
// Self-checking testbench for the hit bucket segmenter with overlap.
// Drives hits over valid/ready, predicts emitted bucket hits and checks them.
// Depends on hbs_pkg, hbs_if and hit_bucket_segmenter_with_overlap_core.
module tb_top;

  localparam int SETTLE_CYCLES = 300;
  localparam int DRAIN_CAP     = 200000;

  // Unused register indexes; writes there must be ignored.
  localparam logic [hbs_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;
  localparam logic [hbs_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP   = 3'd7;

  typedef struct packed {
    logic signed [hbs_pkg::Z_W-1:0] z;
    logic [hbs_pkg::SIGMA_W-1:0]    sigma;
    logic [hbs_pkg::TAG_W-1:0]      tag;
    logic                           sector_end;
  } hit_t;

  typedef struct packed {
    logic [hbs_pkg::BNUM_W-1:0] bnum;
    logic [hbs_pkg::TAG_W-1:0]  tag;
    logic [hbs_pkg::Z_W-1:0]    z;
    logic                       last;
  } bucket_hit_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hbs_pkg::CFG_DATA_W-1:0] cfg_data;

  hbs_in_if  in_ch ();
  hbs_out_if out_ch ();

  hit_bucket_segmenter_with_overlap_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bucket predictor state
  hbs_pkg::cfg_t                      shadow;
  logic signed [hbs_pkg::Z_W-1:0]     bz   [hbs_pkg::BUCKET_DEPTH];
  logic signed [hbs_pkg::UPPER_W-1:0] bup  [hbs_pkg::BUCKET_DEPTH];
  logic [hbs_pkg::TAG_W-1:0]          btag [hbs_pkg::BUCKET_DEPTH];
  int                                 bcount;
  logic signed [hbs_pkg::Z_W-1:0]     bfirst;
  logic [hbs_pkg::BNUM_W-1:0]         nbuckets;

  bucket_hit_t expected_hits [$];
  int          errors;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int          hold_cycles;

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void reset_model();
    shadow.max_window      = hbs_pkg::RST_MAX_WINDOW;
    shadow.neighbor_window = hbs_pkg::RST_NEIGHBOR_WINDOW;
    shadow.overlap_window  = hbs_pkg::RST_OVERLAP_WINDOW;
    shadow.sigma_scale     = hbs_pkg::RST_SIGMA_SCALE;
    shadow.min_bucket_size = hbs_pkg::RST_MIN_BUCKET_SIZE;
    bcount   = 0;
    bfirst   = '0;
    nbuckets = '0;
  endfunction

  // Emit the open bucket if it is big enough
  function automatic void close_bucket();
    bucket_hit_t r;
    int i;
    if (bcount == 0 || bcount < int'(shadow.min_bucket_size)) return;
    nbuckets++;
    for (i = 0; i < bcount; i++) begin
      r.bnum = nbuckets;
      r.tag  = btag[i];
      r.z    = bz[i];
      r.last = (i == bcount - 1);
      expected_hits = {expected_hits, r};
    end
  endfunction

  // Apply one accepted hit to the bucket state
  function automatic void model_hit(hit_t h);
    int  z, upper, keep, base, i;
    bit  split;
    z     = int'($signed(h.z));
    upper = z + ((int'(h.sigma) * int'(shadow.sigma_scale)) >>> 4);
    if (bcount > 0) begin
      split = (bcount >= hbs_pkg::BUCKET_DEPTH)
           || (z - int'(bfirst) > int'(shadow.max_window))
           || (z - int'(bz[bcount-1]) > int'(shadow.neighbor_window));
      if (split) begin
        close_bucket();
        // scan down from the newest entry, stop at the first miss
        keep = 0;
        while (keep < bcount && keep < hbs_pkg::BUCKET_DEPTH - 1
               && z - int'(bup[bcount-1-keep]) < int'(shadow.overlap_window))
          keep++;
        base = bcount - keep;
        for (i = 0; i < keep; i++) begin
          bz[i]   = bz[base+i];
          bup[i]  = bup[base+i];
          btag[i] = btag[base+i];
        end
        bcount = keep;
        bfirst = (keep > 0) ? bz[0] : h.z;
      end
    end
    if (bcount == 0) bfirst = h.z;
    if (bcount < hbs_pkg::BUCKET_DEPTH) begin
      bz[bcount]   = h.z;
      bup[bcount]  = hbs_pkg::UPPER_W'(upper);
      btag[bcount] = h.tag;
      bcount++;
    end
    // sector end flushes and clears the sector state
    if (h.sector_end) begin
      close_bucket();
      bcount   = 0;
      bfirst   = '0;
      nbuckets = '0;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin : result_check
    bucket_hit_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected bucket hit, expected none, got tag %0h z %0h", $time,
                 out_ch.out_tag, out_ch.out_z);
        errors++;
      end else begin
        want = expected_hits.pop_front();
        check_field("bucket_number", want.bnum, out_ch.bucket_number);
        check_field("out_tag", want.tag, out_ch.out_tag);
        check_field("out_z", want.z, out_ch.out_z);
        check_field("bucket_last", want.last, out_ch.bucket_last);
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Register write; called at a falling edge, returns at one
  task automatic cfg_write(logic [hbs_pkg::CFG_IDX_W-1:0] idx,
                           logic [hbs_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    case (idx)
      hbs_pkg::CFG_MAX_WINDOW:      shadow.max_window      = data[hbs_pkg::WIN_W-1:0];
      hbs_pkg::CFG_NEIGHBOR_WINDOW: shadow.neighbor_window = data[hbs_pkg::WIN_W-1:0];
      hbs_pkg::CFG_OVERLAP_WINDOW:  shadow.overlap_window  = data[hbs_pkg::WIN_W-1:0];
      hbs_pkg::CFG_SIGMA_SCALE:     shadow.sigma_scale     = data[hbs_pkg::SCALE_W-1:0];
      hbs_pkg::CFG_MIN_BUCKET_SIZE: shadow.min_bucket_size = data[hbs_pkg::MIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Send one hit item; called at a falling edge, returns at one
  task automatic send_hit(hit_t h);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    in_ch.point_z     = h.z;
    in_ch.point_sigma = h.sigma;
    in_ch.point_tag   = h.tag;
    in_ch.sector_end  = h.sector_end;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    model_hit(h);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic offer_hit(int z, int sigma, int tag, bit last);
    hit_t h;
    h.z          = hbs_pkg::Z_W'(z);
    h.sigma      = hbs_pkg::SIGMA_W'(sigma);
    h.tag        = hbs_pkg::TAG_W'(tag);
    h.sector_end = last;
    send_hit(h);
  endtask

  // Wait until every expected hit is out, then let the block go quiet
  task automatic wait_drained();
    int n;
    n = 0;
    while (expected_hits.size() != 0 && n < DRAIN_CAP) begin
      @(posedge clk);
      n++;
    end
    if (expected_hits.size() != 0) begin
      $display("%0t: %0d expected bucket hits never came out", $time,
               expected_hits.size());
      errors++;
      expected_hits.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Sectors of mostly ascending hits with random gaps; dense ones fill the store
  task automatic run_sectors(int n_items, bit dense);
    int   sent, len, i, gap, r;
    bit   closed;
    logic signed [hbs_pkg::Z_W-1:0] zc;
    hit_t h;
    sent = 0;
    while (sent < n_items) begin
      len    = dense ? $urandom_range(30, 45) : $urandom_range(1, 24);
      closed = ($urandom_range(99) >= 10);
      zc     = hbs_pkg::Z_W'($urandom);
      for (i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (dense) gap = $urandom_range(0, 3);
        else if (r < 45) gap = $urandom_range(0, int'(shadow.neighbor_window) / 2);
        else if (r < 60) gap = int'(shadow.neighbor_window) - 1 + $urandom_range(0, 2);
        else if (r < 70) gap = $urandom_range(0, 2 * int'(shadow.overlap_window));
        else if (r < 80) gap = int'(shadow.neighbor_window) + $urandom_range(0, 60000);
        else if (r < 88) gap = 0 - int'($urandom_range(0, 3000));
        else if (r < 94) begin
          // noise: jump anywhere
          zc  = hbs_pkg::Z_W'($urandom);
          gap = 0;
        end else gap = 0;
        zc = hbs_pkg::Z_W'(int'(zc) + gap);
        r  = $urandom_range(99);
        h.z          = zc;
        h.sigma      = (r < 70) ? hbs_pkg::SIGMA_W'($urandom_range(0, 2000))
                     : (r < 90) ? hbs_pkg::SIGMA_W'($urandom)
                     : ($urandom_range(1) ? '1 : '0);
        h.tag        = hbs_pkg::TAG_W'($urandom);
        h.sector_end = closed && (i == len - 1);
        send_hit(h);
        sent++;
      end
    end
  endtask

  task automatic random_config();
    cfg_write(hbs_pkg::CFG_MAX_WINDOW,
              hbs_pkg::CFG_DATA_W'(($urandom_range(99) < 10) ? 20'hFFFFF
                                                             : $urandom_range(1000, 30000)));
    cfg_write(hbs_pkg::CFG_NEIGHBOR_WINDOW,
              hbs_pkg::CFG_DATA_W'(($urandom_range(99) < 10) ? 20'd0
                                                             : $urandom_range(300, 6000)));
    cfg_write(hbs_pkg::CFG_OVERLAP_WINDOW, hbs_pkg::CFG_DATA_W'($urandom_range(0, 5000)));
    cfg_write(hbs_pkg::CFG_SIGMA_SCALE, hbs_pkg::CFG_DATA_W'($urandom_range(0, 255)));
    cfg_write(hbs_pkg::CFG_MIN_BUCKET_SIZE, hbs_pkg::CFG_DATA_W'($urandom_range(0, 5)));
  endtask

  // Reset settings: first hit, neighbor and window splits, overlap copy,
  // out-of-order z, sector end with two buckets, extreme fields
  task automatic test_default_buckets();
    offer_hit(0, 100, 1, 0);
    offer_hit(1000, 100, 2, 0);
    offer_hit(5001, 100, 3, 0);
    offer_hit(9001, 0, 4, 0);
    offer_hit(12000, 2000, 5, 0);
    offer_hit(16000, 0, 6, 0);
    offer_hit(19000, 500, 7, 0);
    offer_hit(21002, 0, 8, 0);
    offer_hit(20500, 0, 9, 0);
    offer_hit(22000, 65535, 10, 1);
    offer_hit(-524288, 65535, 16'hFFFF, 0);
    offer_hit(524287, 65535, 0, 1);
    wait_drained();
  endtask

  // Register extremes, masking of wide data and ignored indexes
  task automatic test_config_extremes();
    cfg_write(hbs_pkg::CFG_MAX_WINDOW, 20'd0);
    cfg_write(hbs_pkg::CFG_NEIGHBOR_WINDOW, 20'd0);
    cfg_write(hbs_pkg::CFG_OVERLAP_WINDOW, 20'hFFFFF);
    cfg_write(hbs_pkg::CFG_SIGMA_SCALE, 20'hFFFFF);
    cfg_write(hbs_pkg::CFG_MIN_BUCKET_SIZE, 20'd0);
    offer_hit(100, 0, 16'h1111, 0);
    offer_hit(100, 65535, 16'h2222, 0);
    offer_hit(101, 0, 16'h3333, 0);
    offer_hit(101, 300, 16'h4444, 0);
    offer_hit(-524288, 0, 16'h5555, 1);
    wait_drained();
    // minimum above the store depth: nothing may come out
    cfg_write(hbs_pkg::CFG_MAX_WINDOW, 20'hFFFFF);
    cfg_write(hbs_pkg::CFG_NEIGHBOR_WINDOW, 20'hFFFFF);
    cfg_write(hbs_pkg::CFG_OVERLAP_WINDOW, 20'd0);
    cfg_write(hbs_pkg::CFG_SIGMA_SCALE, 20'hABC10);
    cfg_write(hbs_pkg::CFG_MIN_BUCKET_SIZE, 20'hFFFE1);
    cfg_write(CFG_IDX_SPARE, 20'd0);
    cfg_write(CFG_IDX_TOP, 20'd1);
    offer_hit(-524288, 7, 16'hAAAA, 0);
    offer_hit(0, 7, 16'h5555, 0);
    offer_hit(524287, 7, 16'hFFFF, 1);
    wait_drained();
  endtask

  // Receiver holds off while hits keep coming, then the sender waits it out
  task automatic test_backpressure();
    int i;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    cfg_write(hbs_pkg::CFG_MAX_WINDOW, 20'd16000);
    cfg_write(hbs_pkg::CFG_NEIGHBOR_WINDOW, 20'd4000);
    cfg_write(hbs_pkg::CFG_OVERLAP_WINDOW, 20'd1600);
    cfg_write(hbs_pkg::CFG_SIGMA_SCALE, 20'd16);
    cfg_write(hbs_pkg::CFG_MIN_BUCKET_SIZE, 20'd1);
    @(posedge clk);
    hold_cycles = 400;
    @(negedge clk);
    for (i = 0; i < 30; i++)
      offer_hit(-400000 + i * 2600, $urandom_range(0, 3000), $urandom, i == 29);
    wait_drained();
  endtask

  // Dense sectors that run the store full
  task automatic test_full_store();
    src_idle_pct   = 19;
    sink_stall_pct = 19;
    cfg_write(hbs_pkg::CFG_MAX_WINDOW, 20'hFFFFF);
    cfg_write(hbs_pkg::CFG_NEIGHBOR_WINDOW, 20'hFFFFF);
    cfg_write(hbs_pkg::CFG_OVERLAP_WINDOW, hbs_pkg::CFG_DATA_W'($urandom_range(0, 300)));
    cfg_write(hbs_pkg::CFG_SIGMA_SCALE, 20'd16);
    cfg_write(hbs_pkg::CFG_MIN_BUCKET_SIZE, hbs_pkg::CFG_DATA_W'($urandom_range(0, 2)));
    run_sectors(40, 1'b1);
    wait_drained();
  endtask

  // Random sectors under each idling mix, fresh settings per phase
  task automatic test_random_traffic();
    int unsigned idle_mix  [4] = '{0, 61, 0, 19};
    int unsigned stall_mix [4] = '{0, 0, 61, 19};
    int p;
    for (p = 0; p < 4; p++) begin
      src_idle_pct   = idle_mix[p];
      sink_stall_pct = stall_mix[p];
      random_config();
      run_sectors(55, 1'b0);
      wait_drained();
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.point_z  = '0;
    in_ch.point_sigma = '0;
    in_ch.point_tag   = '0;
    in_ch.sector_end  = 1'b0;
    out_ch.ready   = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_cycles    = 0;
    errors         = 0;
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_buckets();
    test_config_extremes();
    test_backpressure();
    test_full_store();
    test_random_traffic();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
